[rtl/ssp_pkg.sv]
// ----------------------------------------------------------------------------
// Servo status packet parser package
// Shared constants and the result type passed from the parser to the
// output buffer.
// ----------------------------------------------------------------------------
package ssp_pkg;

   localparam logic [7:0] PREAMBLE_BYTE   = 8'hFF;
   localparam logic [7:0] LEN_OVERHEAD    = 8'd2;
   localparam logic [7:0] MAX_PARAM_RESET = 8'd253;

   localparam logic KIND_PARAM   = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef struct packed {
      logic       result_kind;
      logic [7:0] param_byte;
      logic [7:0] param_index;
      logic [7:0] servo_id;
      logic [7:0] error_bits;
      logic [7:0] param_total;
      logic       checksum_good;
   } result_type;

endpackage

[rtl/servo_status_packet_parser_top.sv]
// ----------------------------------------------------------------------------
// Servo status packet parser
// Deframes servo status packets from a received byte stream, passes each
// parameter byte on as it arrives and reports a summary at packet end.
//
//   Channel  Direction  Handshake            Contents
//   req_     in         req_valid/req_stall  one received byte per beat
//   rsp_     out        rsp_valid/rsp_stall  parameter byte or packet summary
//   csr_     in         csr_wr_en            largest accepted parameter count
//
// One byte is taken every cycle while req_stall is low; its result, if any, is
// registered in a two-entry output buffer and presented on the response channel.
// Reset is synchronous and returns the parser to hunting the first preamble
// byte with the parameter limit at 253.
// req_stall rises only when both buffer entries hold results not yet taken.
// ----------------------------------------------------------------------------
module servo_status_packet_parser_top
   import ssp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_result_kind,
   output logic [7:0] rsp_param_byte,
   output logic [7:0] rsp_param_index,
   output logic [7:0] rsp_servo_id,
   output logic [7:0] rsp_error_bits,
   output logic [7:0] rsp_param_total,
   output logic       rsp_checksum_good,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);

   logic [7:0] max_param_ff;
   logic       req_accept;
   logic       res_valid;
   logic       buf_full;
   result_type res;
   result_type head;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_param_ff <= MAX_PARAM_RESET;
      end else if (csr_wr_en) begin
         max_param_ff <= csr_wr_data;
      end
   end

   assign req_stall  = buf_full;
   assign req_accept = req_valid && !req_stall;

   ssp_parser u_parser (
      .clock           (clock),
      .reset           (reset),
      .byte_accept     (req_accept),
      .rx_byte         (req_rx_byte),
      .max_param_count (max_param_ff),
      .res_valid       (res_valid),
      .res             (res)
   );

   ssp_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .full      (buf_full),
      .pop_valid (rsp_valid),
      .pop_stall (rsp_stall),
      .pop_data  (head)
   );

   assign rsp_result_kind   = head.result_kind;
   assign rsp_param_byte    = head.param_byte;
   assign rsp_param_index   = head.param_index;
   assign rsp_servo_id      = head.servo_id;
   assign rsp_error_bits    = head.error_bits;
   assign rsp_param_total   = head.param_total;
   assign rsp_checksum_good = head.checksum_good;

   a_result_needs_accept: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> req_accept)
      else $error("parser produced a result without an accepted byte");

   a_stall_means_pending: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled while no result is pending");

   a_result_shows_next: assert property (@(posedge clock) disable iff (reset)
      (res_valid && !rsp_valid) |=> rsp_valid)
      else $error("result not presented the cycle after it was produced");

   a_summary_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result_kind == KIND_SUMMARY) |->
      (rsp_param_byte == 8'd0 && rsp_param_index == 8'd0))
      else $error("summary carries parameter fields");

endmodule

[rtl/ssp_parser.sv]
// ----------------------------------------------------------------------------
// Servo status packet parser core
// Deframing state machine with running checksum; produces at most one
// result for every accepted byte in the same cycle.
// ----------------------------------------------------------------------------
module ssp_parser
   import ssp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       byte_accept,
   input  logic [7:0] rx_byte,
   input  logic [7:0] max_param_count,
   output logic       res_valid,
   output result_type res
);

   typedef enum logic [2:0] {
      PH_HUNT0 = 3'd0,
      PH_HUNT1 = 3'd1,
      PH_ID    = 3'd2,
      PH_LEN   = 3'd3,
      PH_ERR   = 3'd4,
      PH_PARAM = 3'd5,
      PH_CSUM  = 3'd6
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [7:0] length_ff, length_in;
   logic [7:0] seen_ff, seen_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] id_ff, id_in;
   logic [7:0] err_ff, err_in;
   logic [7:0] expected;
   logic [7:0] seen_next;
   logic [7:0] len_minus;

   assign expected  = length_ff - LEN_OVERHEAD;
   assign seen_next = seen_ff + 8'd1;
   assign len_minus = rx_byte - LEN_OVERHEAD;

   always_comb begin
      phase_in  = phase_ff;
      length_in = length_ff;
      seen_in   = seen_ff;
      sum_in    = sum_ff;
      id_in     = id_ff;
      err_in    = err_ff;
      res_valid = 1'b0;
      res       = '0;
      res.servo_id   = id_ff;
      res.error_bits = err_ff;
      unique case (phase_ff)
         PH_HUNT0: begin
            if (rx_byte == PREAMBLE_BYTE) begin
               phase_in = PH_HUNT1;
            end
         end
         PH_HUNT1: begin
            phase_in = (rx_byte == PREAMBLE_BYTE) ? PH_ID : PH_HUNT0;
         end
         PH_ID: begin
            id_in    = rx_byte;
            phase_in = PH_LEN;
         end
         PH_LEN: begin
            if (rx_byte < LEN_OVERHEAD || len_minus > max_param_count) begin
               phase_in = PH_HUNT0;
            end else begin
               length_in = rx_byte;
               sum_in    = id_ff + rx_byte;
               phase_in  = PH_ERR;
            end
         end
         PH_ERR: begin
            err_in   = rx_byte;
            sum_in   = sum_ff + rx_byte;
            seen_in  = 8'd0;
            phase_in = (length_ff == LEN_OVERHEAD) ? PH_CSUM : PH_PARAM;
         end
         PH_PARAM: begin
            res_valid       = 1'b1;
            res.result_kind = KIND_PARAM;
            res.param_byte  = rx_byte;
            res.param_index = seen_ff;
            res.param_total = expected;
            sum_in          = sum_ff + rx_byte;
            seen_in         = seen_next;
            if (seen_next >= expected) begin
               phase_in = PH_CSUM;
            end
         end
         PH_CSUM: begin
            res_valid         = 1'b1;
            res.result_kind   = KIND_SUMMARY;
            res.param_total   = seen_ff;
            res.checksum_good = (~sum_ff == rx_byte);
            phase_in          = PH_HUNT0;
         end
         default: begin
            phase_in = PH_HUNT0;
         end
      endcase
      if (!byte_accept) begin
         res_valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT0;
         length_ff <= 8'd0;
         seen_ff   <= 8'd0;
         sum_ff    <= 8'd0;
         id_ff     <= 8'd0;
         err_ff    <= 8'd0;
      end else if (byte_accept) begin
         phase_ff  <= phase_in;
         length_ff <= length_in;
         seen_ff   <= seen_in;
         sum_ff    <= sum_in;
         id_ff     <= id_in;
         err_ff    <= err_in;
      end
   end

endmodule

[rtl/ssp_out_buf.sv]
// ----------------------------------------------------------------------------
// Servo status packet parser output buffer
// Two-entry result register with skid space, so a new byte can be taken
// while a finished result still waits on the response channel.
// ----------------------------------------------------------------------------
module ssp_out_buf
   import ssp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_data,
   output logic       full,
   output logic       pop_valid,
   input  logic       pop_stall,
   output result_type pop_data
);

   result_type entry_ff [2];
   logic [1:0] count_ff, count_in;
   logic       wr_ptr_ff, rd_ptr_ff;
   logic       pop;

   assign full      = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign pop       = pop_valid && !pop_stall;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
